@@ rtl/b2d_pkg.sv @@
`default_nettype none

package b2d_pkg;

    // Width of the value port and default number of bits that take part.
    localparam int VALUE_W        = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Result field widths.
    localparam int CHAR_W  = 6;
    localparam int COUNT_W = 5;
    localparam int DIGIT_W = 4;

    // ASCII code of '0'; a BCD digit is ORed into its low bits.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    // Decimal digit threshold at which double dabble adds three.
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    // Control from the sequencer to the conversion unit.
    typedef struct packed {
        logic load;
        logic step;
    } dab_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/b2d_dabble.sv @@
`default_nettype none

// Bit-serial double dabble unit. One binary bit enters the BCD register per
// step, after every digit of five or more has been corrected by three. The
// count of significant digits is kept up to date as the value grows.
module b2d_dabble
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NUM_DIGITS = 20,
    localparam int IDX_W     = $clog2(NUM_DIGITS),
    localparam int BCD_W     = DIGIT_W * NUM_DIGITS
) (
    input  wire logic                  aclk,
    input  wire dab_ctrl_t             ctrl,
    input  wire logic [VALUE_BITS-1:0] load_value,
    output logic      [BCD_W-1:0]      bcd,
    output logic      [COUNT_W-1:0]    total
);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [COUNT_W-1:0]    total_reg;

    logic [BCD_W-1:0]      adjusted;
    logic [BCD_W-1:0]      shifted;
    logic [DIGIT_W-1:0]    new_digit;
    logic [COUNT_W-1:0]    total_next;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign shifted = {adjusted[BCD_W-2:0], bin_reg[VALUE_BITS-1]};

    // The value at most doubles plus one per step, so a new significant digit
    // can only show up directly above the current top digit.
    always_comb begin
        new_digit  = '0;
        total_next = total_reg;
        if (total_reg < COUNT_W'(NUM_DIGITS)) begin
            new_digit = shifted[total_reg[IDX_W-1:0]*DIGIT_W +: DIGIT_W];
            if (new_digit != '0) begin
                total_next = total_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            bin_reg   <= load_value;
            bcd_reg   <= '0;
            total_reg <= COUNT_W'(1);
        end else if (ctrl.step) begin
            bin_reg   <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg   <= shifted;
            total_reg <= total_next;
        end
    end

    assign bcd   = bcd_reg;
    assign total = total_reg;

endmodule

`default_nettype wire

@@ rtl/binary_to_decimal_ascii.sv @@
`default_nettype none

// Binary to decimal ASCII converter. Each item on the s_ channel is an
// unsigned value, of which only the low VALUE_BITS bits take part. The block
// answers with one m_ item per decimal digit, most significant digit first,
// with no leading zeros; a value of zero gives the single digit '0'. Every
// digit item carries its ASCII code, its position (0 is the most significant
// digit), the total digit count and a flag on the final digit. A value
// that is taken in goes to the bit-serial double dabble unit, which makes
// one shift and add-three correction per cycle until every binary bit is
// in; the digits then leave one by one, as m_ready allows. s_ready is high
// only while the unit is idle; the last digit may still wait in the output
// register while the next value is taken in. No state is kept between values.
module binary_to_decimal_ascii
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_value,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [CHAR_W-1:0]  m_digit_char,
    output logic      [COUNT_W-1:0] m_digit_index,
    output logic      [COUNT_W-1:0] m_digit_total,
    output logic                    m_last_digit
);

    // Decimal digits needed for the largest value of VALUE_BITS bits:
    // floor(VALUE_BITS * log10(2)) + 1.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int BITCNT_W   = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [BITCNT_W-1:0]   bit_cnt_reg;
    logic [COUNT_W-1:0]    idx_reg;

    logic                  m_valid_reg;
    logic [CHAR_W-1:0]     m_char_reg;
    logic [COUNT_W-1:0]    m_index_reg;
    logic [COUNT_W-1:0]    m_total_reg;
    logic                  m_last_reg;

    dab_ctrl_t             dab_ctrl;
    logic [BCD_W-1:0]      bcd;
    logic [COUNT_W-1:0]    total;

    logic                  accept;
    logic                  out_free;
    logic [COUNT_W-1:0]    pos;
    logic [DIGIT_W-1:0]    digit_sel;
    logic                  is_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign dab_ctrl.load = accept;
    assign dab_ctrl.step = (state_reg == ST_CONV);

    b2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .aclk       (aclk),
        .ctrl       (dab_ctrl),
        .load_value (s_value[VALUE_BITS-1:0]),
        .bcd        (bcd),
        .total      (total)
    );

    // Digits leave most significant first: the k-th item shows the digit at
    // position total-1-k of the BCD register.
    assign pos       = total - COUNT_W'(1) - idx_reg;
    assign digit_sel = bcd[pos[IDX_W-1:0]*DIGIT_W +: DIGIT_W];
    assign is_last   = (idx_reg == total - COUNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // While digits are being emitted the output register is
            // refilled or kept below, so it is only drained here otherwise.
            if (m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        bit_cnt_reg <= BITCNT_W'(VALUE_BITS - 1);
                        state_reg   <= ST_CONV;
                    end
                end

                ST_CONV: begin
                    // The step on the cycle where the count reads zero shifts
                    // in the final binary bit.
                    if (bit_cnt_reg == '0) begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        bit_cnt_reg <= bit_cnt_reg - BITCNT_W'(1);
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_char_reg  <= ASCII_ZERO | CHAR_W'(digit_sel);
                        m_index_reg <= idx_reg;
                        m_total_reg <= total;
                        m_last_reg  <= is_last;
                        idx_reg     <= idx_reg + COUNT_W'(1);
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digit_char  = m_char_reg;
    assign m_digit_index = m_index_reg;
    assign m_digit_total = m_total_reg;
    assign m_last_digit  = m_last_reg;

`ifndef ASSERT_OFF
    // The final digit of a run sits at the last position, and only there.
    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_digit == (m_digit_index == m_digit_total - COUNT_W'(1))))
        else $error("last_digit flag does not match digit position");

    // Every emitted character is a decimal digit.
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_char >= ASCII_ZERO && m_digit_char <= ASCII_ZERO + CHAR_W'(9)))
        else $error("digit character outside '0' to '9'");

    // The digit count stays within what VALUE_BITS can produce.
    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_total != '0 && m_digit_total <= COUNT_W'(NUM_DIGITS)))
        else $error("digit total out of range");

    // No leading zero: a run of more than one digit starts with a nonzero one.
    a_no_leading_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_digit_index == '0 && m_digit_total != COUNT_W'(1))
            |-> (m_digit_char != ASCII_ZERO))
        else $error("leading zero emitted");

    // After a value is taken in, the unit is busy converting.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while converting");
`endif

endmodule

`default_nettype wire

@@ tb/binary_to_decimal_ascii_tb.sv @@
`default_nettype none

module binary_to_decimal_ascii_tb;
    import b2d_pkg::*;

    // The block is built with its default width, so every bit of s_value
    // takes part in the conversion.
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_W) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

    localparam int MAX_DIGITS  = 20;
    localparam int DEC_RADIX   = 10;
    localparam int NUM_DIR     = 18;
    localparam int NUM_RANDOM  = 112;

    // Enough cycles after the last expected digit for a whole conversion,
    // so that a stray extra digit item would still show up.
    localparam int DRAIN_CYCLES = 200;

    // Slowest correct run: every item with 20 digits, each digit waiting
    // out a full receiver hold, plus the longest sender gap and the block's
    // own conversion time. The limit is far above that.
    localparam int TIMEOUT_UNITS = 5_000_000;

    // One expected digit item, with the same fields as the m_ channel.
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] pos;
        logic [COUNT_W-1:0] count;
        logic               is_last;
    } digit_t;

    // A directed item. Where the decimal text is obvious it is typed in and
    // used as the expectation; an empty text means the predictor decides.
    typedef struct {
        logic [VALUE_W-1:0] value;
        string              text;
    } dir_row_t;

    // Receiver behavior, changed segment by segment.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAR_W-1:0]  m_digit_char;
    logic [COUNT_W-1:0] m_digit_index;
    logic [COUNT_W-1:0] m_digit_total;
    logic               m_last_digit;

    digit_t             pending_digits[$];
    logic [VALUE_W-1:0] dec_power[MAX_DIGITS];
    logic [MAX_DIGITS:0] totals_seen = '0;
    int                 errors         = 0;
    int                 values_sent    = 0;
    int                 digits_checked = 0;
    rx_mode_t           rx_mode        = RX_OPEN;
    int                 rx_left        = 0;

    dir_row_t dir_rows[NUM_DIR] = '{
        '{64'd0,                    "0"},
        '{64'd1,                    "1"},
        '{64'd9,                    "9"},
        '{64'd10,                   "10"},
        '{64'd99,                   "99"},
        '{64'd100,                  "100"},
        '{64'hFFFF_FFFF_FFFF_FFFF,  "18446744073709551615"},
        '{64'd10000000000000000000, "10000000000000000000"},
        '{64'd9999999999999999999,  "9999999999999999999"},
        '{64'h8000_0000_0000_0000,  ""},
        '{64'h7FFF_FFFF_FFFF_FFFF,  ""},
        '{64'hAAAA_AAAA_AAAA_AAAA,  ""},
        '{64'h5555_5555_5555_5555,  ""},
        '{64'h0000_0000_FFFF_FFFF,  ""},
        '{64'h0000_0001_0000_0000,  ""},
        '{64'd1000000000,           ""},
        '{64'd999999999,            ""},
        '{64'd12345,                ""}
    };

    binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_digit_index(m_digit_index),
        .m_digit_total(m_digit_total),
        .m_last_digit (m_last_digit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Queues the digit items that one accepted value must produce. A typed
    // text is taken as it stands; otherwise the value is masked to the
    // active width and split into decimal digits, least significant first,
    // then queued most significant first.
    function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] raw,
                                                 input string text);
        logic [VALUE_W-1:0] rest;
        logic [3:0]         digs[MAX_DIGITS];
        byte                c;
        int                 n;
        digit_t             d;

        if (text.len() != 0) begin
            for (int k = 0; k < text.len(); k++) begin
                c         = text[k];
                d.ch      = c[CHAR_W-1:0];
                d.pos     = COUNT_W'(k);
                d.count   = COUNT_W'(text.len());
                d.is_last = (k == text.len() - 1);
                pending_digits.push_back(d);
            end
        end else begin
            rest = raw & VALUE_MASK;
            n    = 0;
            do begin
                digs[n] = 4'(rest % DEC_RADIX);
                rest    = rest / DEC_RADIX;
                n++;
            end while (rest != 0 && n < MAX_DIGITS);
            for (int k = 0; k < n; k++) begin
                d.ch      = ASCII_ZERO + CHAR_W'(digs[n-1-k]);
                d.pos     = COUNT_W'(k);
                d.count   = COUNT_W'(n);
                d.is_last = (k == n - 1);
                pending_digits.push_back(d);
            end
        end
    endfunction

    // Random values are spread over all digit counts: full 64-bit values
    // mostly give 19 or 20 digits, so a good share is cut to a random bit
    // width, kept small, or placed right around a power of ten where the
    // digit count changes.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 w;
        int                 k;

        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
            end
            4, 5: begin
                w = $urandom_range(1, VALUE_W);
                if (w < VALUE_W) begin
                    v &= (64'd1 << w) - 64'd1;
                end
                v[w-1] = 1'b1;
            end
            6: v = VALUE_W'($urandom_range(0, 999));
            7, 8: begin
                k = $urandom_range(1, MAX_DIGITS - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = dec_power[k] - 64'd1 - VALUE_W'($urandom_range(0, 3));
                end else begin
                    v = dec_power[k] + VALUE_W'($urandom_range(0, 3));
                end
            end
            default: begin
                // Either a lone set bit or all ones up to a random width.
                w = $urandom_range(0, VALUE_W - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = 64'd1 << w;
                end else begin
                    v = '1 >> w;
                end
            end
        endcase
        return v;
    endfunction

    // Receiver: segments of random length, each with its own stall pattern.
    // Open segments give long stretches with no back pressure; hold
    // segments keep a digit waiting in the output register for a while.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 15)
                                               : $urandom_range(8, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_left % 3 == 0);
                default:   m_ready <= 1'b0;
            endcase
        end
    end

    // Every digit item taken at a rising edge is compared with the oldest
    // expectation, field by field.
    always @(posedge aclk) begin : digit_check
        digit_t want;

        if (aresetn && m_valid && m_ready) begin
            if (pending_digits.size() == 0) begin
                $error("digit item with nothing expected: char %0h index %0d total %0d",
                       m_digit_char, m_digit_index, m_digit_total);
                errors++;
            end else begin
                want = pending_digits.pop_front();
                digits_checked++;
                totals_seen[want.count] = 1'b1;
                if (m_digit_char !== want.ch) begin
                    $error("digit_char: expected %0h, got %0h", want.ch, m_digit_char);
                    errors++;
                end
                if (m_digit_index !== want.pos) begin
                    $error("digit_index: expected %0d, got %0d", want.pos, m_digit_index);
                    errors++;
                end
                if (m_digit_total !== want.count) begin
                    $error("digit_total: expected %0d, got %0d", want.count, m_digit_total);
                    errors++;
                end
                if (m_last_digit !== want.is_last) begin
                    $error("last_digit: expected %0b, got %0b", want.is_last, m_last_digit);
                    errors++;
                end
            end
        end
    end

    // Sender: the directed table first, then random values. Items go out in
    // bursts of random length; between bursts valid may drop for a random gap,
    // sometimes short and sometimes long enough to reach into the digit
    // output of the previous value. Payload is noise while valid is low.
    initial begin : stimulus
        logic [VALUE_W-1:0] v;
        string              text;
        int                 burst_left;
        int                 gap;

        dec_power[0] = 64'd1;
        for (int k = 1; k < MAX_DIGITS; k++) begin
            dec_power[k] = dec_power[k-1] * DEC_RADIX;
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        burst_left = $urandom_range(1, 6);
        for (int i = 0; i < NUM_DIR + NUM_RANDOM; i++) begin
            if (i < NUM_DIR) begin
                v    = dir_rows[i].value;
                text = dir_rows[i].text;
            end else begin
                v    = random_value();
                text = "";
            end
            s_valid <= 1'b1;
            s_value <= v;
            do @(posedge aclk); while (!s_ready);
            queue_decimal_digits(v, text);
            values_sent++;
            @(negedge aclk);

            burst_left--;
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90)
                                                  : $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    s_value <= {$urandom, $urandom};
                    repeat (gap) @(negedge aclk);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("converted %0d values (%0d from the directed table), checked %0d digit items",
                 values_sent, NUM_DIR, digits_checked);
        $display("digit counts seen: %0d of %0d, mismatches: %0d",
                 $countones(totals_seen), MAX_DIGITS, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct one.
    initial begin : watchdog
        #(TIMEOUT_UNITS);
        $display("timeout with %0d digit items still expected", pending_digits.size());
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
